// ===== src/dbrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrgb_pkg: shared types and constants of the decibel to rgb colormap
// Holds the pixel class codes, the divider item, the color table and the
// register indexes of the configuration port.
// ----------------------------------------------------------------------------
package dbrgb_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FLOOR_DB  = 1'b0,
		CFG_GRAY_MODE = 1'b1
	} cfg_reg_t;

	localparam logic [15:0] FLOOR_DB_RESET = 16'd46080;

	// field widths
	localparam int LEVEL_W = 17;
	localparam int DYN_W   = 16;
	localparam int CH_W    = 8;

	// scaled quotient: gray uses mag*255/d, color uses mag*18*256/d
	localparam int QUO_W = 13;
	localparam int NUM_W = 29;
	localparam int SCL_W = 13;

	localparam logic [SCL_W-1:0] NUM_SCALE_GRAY  = 13'd255;
	localparam logic [SCL_W-1:0] NUM_SCALE_COLOR = 13'd4608;
	// black once the quotient reaches these limits
	localparam logic [SCL_W-1:0] LIMIT_GRAY  = 13'd255;
	localparam logic [SCL_W-1:0] LIMIT_COLOR = 13'd4864;

	localparam int ROW_W = 5;
	localparam logic [ROW_W-1:0] LAST_ROW = 5'd18;

	typedef enum logic [1:0] {
		KIND_WHITE,
		KIND_BLACK,
		KIND_GRAY,
		KIND_COLOR
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [NUM_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} div_item_t;

	// element 0 is red, 1 green, 2 blue
	typedef logic [0:2][CH_W-1:0] rgb_t;

	function automatic rgb_t color_row(input logic [ROW_W-1:0] idx);
		rgb_t row;
		case (idx)
			5'd0:    row = {8'd255, 8'd255, 8'd255};
			5'd1:    row = {8'd240, 8'd254, 8'd216};
			5'd2:    row = {8'd242, 8'd251, 8'd185};
			5'd3:    row = {8'd253, 8'd245, 8'd143};
			5'd4:    row = {8'd253, 8'd200, 8'd102};
			5'd5:    row = {8'd252, 8'd144, 8'd66};
			5'd6:    row = {8'd252, 8'd75,  8'd32};
			5'd7:    row = {8'd237, 8'd28,  8'd41};
			5'd8:    row = {8'd214, 8'd3,   8'd64};
			5'd9:    row = {8'd183, 8'd3,   8'd101};
			5'd10:   row = {8'd157, 8'd3,   8'd122};
			5'd11:   row = {8'd122, 8'd3,   8'd126};
			5'd12:   row = {8'd80,  8'd2,   8'd110};
			5'd13:   row = {8'd45,  8'd2,   8'd89};
			5'd14:   row = {8'd19,  8'd2,   8'd70};
			5'd15:   row = {8'd1,   8'd3,   8'd53};
			5'd16:   row = {8'd1,   8'd3,   8'd37};
			5'd17:   row = {8'd1,   8'd2,   8'd19};
			default: row = {8'd0,   8'd0,   8'd0};
		endcase
		return row;
	endfunction

endpackage

// ===== src/dbrgb_level_if.sv =====
// ----------------------------------------------------------------------------
// dbrgb_level_if: pixel level channel
// Carries one signed Q8.8 dB level per request.
// ----------------------------------------------------------------------------
interface dbrgb_level_if;
	logic                 valid;
	logic                 ready;
	logic signed [16:0]   level_db;

	modport source (output valid, output level_db, input ready);
	modport sink   (input valid, input level_db, output ready);
endinterface

// ===== src/dbrgb_rgb_if.sv =====
// ----------------------------------------------------------------------------
// dbrgb_rgb_if: pixel color channel
// Carries one 8-bit red, green and blue triple per request.
// ----------------------------------------------------------------------------
interface dbrgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== src/dbrgb_front.sv =====
// ----------------------------------------------------------------------------
// dbrgb_front: level scaling and pixel classification
// Two stages: scale the level magnitude and the range limit, then compare
// them to sort the pixel into white, black, gray or color.
// ----------------------------------------------------------------------------
module dbrgb_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dbrgb_pkg::DYN_W-1:0]         floor_db,
	input  logic                                gray_mode,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [dbrgb_pkg::LEVEL_W-1:0] level_db,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dbrgb_pkg::div_item_t                out_item
);

	logic [dbrgb_pkg::LEVEL_W-1:0] mag;
	logic [dbrgb_pkg::SCL_W-1:0]   scale;
	logic [dbrgb_pkg::SCL_W-1:0]   limit;
	logic [dbrgb_pkg::NUM_W-1:0]   num_prod;
	logic [dbrgb_pkg::NUM_W-1:0]   thr_prod;

	logic                          v_s1;
	logic                          neg_s1;
	logic                          gray_s1;
	logic [dbrgb_pkg::NUM_W-1:0]   num_s1;
	logic [dbrgb_pkg::NUM_W-1:0]   thr_s1;
	logic                          v_s2;
	dbrgb_pkg::div_item_t          item_s2;
	dbrgb_pkg::kind_t              kind;
	logic                          rdy_s1;
	logic                          rdy_s2;

	// magnitude of a negative level, 1..65536
	assign mag   = ~$unsigned(level_db) + 17'd1;
	assign scale = gray_mode ? dbrgb_pkg::NUM_SCALE_GRAY : dbrgb_pkg::NUM_SCALE_COLOR;
	assign limit = gray_mode ? dbrgb_pkg::LIMIT_GRAY : dbrgb_pkg::LIMIT_COLOR;

	assign num_prod = dbrgb_pkg::NUM_W'(mag) * dbrgb_pkg::NUM_W'(scale);
	assign thr_prod = dbrgb_pkg::NUM_W'(floor_db) * dbrgb_pkg::NUM_W'(limit);

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		if (!neg_s1) begin
			kind = dbrgb_pkg::KIND_WHITE;
		end else if (num_s1 >= thr_s1) begin
			kind = dbrgb_pkg::KIND_BLACK;
		end else if (gray_s1) begin
			kind = dbrgb_pkg::KIND_GRAY;
		end else begin
			kind = dbrgb_pkg::KIND_COLOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			neg_s1  <= level_db[dbrgb_pkg::LEVEL_W-1];
			gray_s1 <= gray_mode;
			num_s1  <= num_prod;
			thr_s1  <= thr_prod;
		end
		if (rdy_s2 && v_s1) begin
			item_s2.kind <= kind;
			item_s2.rem  <= num_s1;
			item_s2.quo  <= '0;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

// ===== src/dbrgb_div.sv =====
// ----------------------------------------------------------------------------
// dbrgb_div: pipelined restoring divider
// One quotient bit per stage, MSB first; the divisor is the dynamic range
// register; users must hold it still while pixels are in flight (unchecked).
// ----------------------------------------------------------------------------
module dbrgb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dbrgb_pkg::DYN_W-1:0] floor_db,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dbrgb_pkg::div_item_t        in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output dbrgb_pkg::div_item_t        out_item
);

	localparam int NSTG = dbrgb_pkg::QUO_W;

	logic                 v_s   [NSTG];
	dbrgb_pkg::div_item_t stg_s [NSTG];
	logic                 rdy   [NSTG+1];

	assign rdy[NSTG] = out_ready;
	assign in_ready  = rdy[0];

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		localparam int BIT = NSTG - 1 - k;

		logic                          src_v;
		dbrgb_pkg::div_item_t          src;
		dbrgb_pkg::div_item_t          nxt;
		logic [dbrgb_pkg::NUM_W-1:0]   dsh;

		if (k == 0) begin : g_first
			assign src_v = in_valid;
			assign src   = in_item;
		end else begin : g_next
			assign src_v = v_s[k-1];
			assign src   = stg_s[k-1];
		end

		assign dsh    = dbrgb_pkg::NUM_W'(floor_db) << BIT;
		assign rdy[k] = !v_s[k] || rdy[k+1];

		always_comb begin
			nxt = src;
			if (src.rem >= dsh) begin
				nxt.rem      = src.rem - dsh;
				nxt.quo[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_v) begin
				stg_s[k] <= nxt;
			end
		end
	end

	assign out_valid = v_s[NSTG-1];
	assign out_item  = stg_s[NSTG-1];

endmodule

// ===== src/dbrgb_blend.sv =====
// ----------------------------------------------------------------------------
// dbrgb_blend: table blend and output register
// Looks up two neighboring color rows, weights them by the fraction, then
// rounds and picks the final color; the second stage is the output register.
// ----------------------------------------------------------------------------
module dbrgb_blend (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  dbrgb_pkg::div_item_t       in_item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dbrgb_pkg::CH_W-1:0] red,
	output logic [dbrgb_pkg::CH_W-1:0] green,
	output logic [dbrgb_pkg::CH_W-1:0] blue
);

	logic [dbrgb_pkg::ROW_W-1:0] idx;
	logic [dbrgb_pkg::ROW_W-1:0] idx_nxt;
	logic [7:0]                  frac;
	logic [8:0]                  wlo;
	dbrgb_pkg::rgb_t             row_a;
	dbrgb_pkg::rgb_t             row_b;

	logic                        v_s1;
	dbrgb_pkg::kind_t            kind_s1;
	logic [7:0]                  gray_s1;
	logic [16:0]                 lo_s1 [3];
	logic [15:0]                 hi_s1 [3];
	logic                        v_s2;
	dbrgb_pkg::rgb_t             rgb_s2;
	dbrgb_pkg::rgb_t             pick;
	dbrgb_pkg::rgb_t             mix;
	logic                        rdy_s1;
	logic                        rdy_s2;

	assign idx     = in_item.quo[dbrgb_pkg::QUO_W-1:8];
	assign frac    = in_item.quo[7:0];
	assign wlo     = 9'd256 - 9'(frac);
	assign idx_nxt = (idx == dbrgb_pkg::LAST_ROW) ? idx : idx + 5'd1;
	assign row_a   = dbrgb_pkg::color_row(idx);
	assign row_b   = dbrgb_pkg::color_row(idx_nxt);

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		logic [17:0] sum;
		for (int c = 0; c < 3; c++) begin
			sum    = 18'(lo_s1[c]) + 18'(hi_s1[c]) + 18'd128;
			mix[c] = sum[15:8];
		end
		case (kind_s1)
			dbrgb_pkg::KIND_WHITE: pick = {3{8'd255}};
			dbrgb_pkg::KIND_BLACK: pick = '0;
			dbrgb_pkg::KIND_GRAY:  pick = {3{gray_s1}};
			dbrgb_pkg::KIND_COLOR: pick = mix;
			default:               pick = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			kind_s1 <= in_item.kind;
			gray_s1 <= 8'd255 - frac;
			for (int c = 0; c < 3; c++) begin
				lo_s1[c] <= 17'(row_a[c]) * 17'(wlo);
				hi_s1[c] <= 16'(row_b[c]) * 16'(frac);
			end
		end
		if (rdy_s2 && v_s1) begin
			rgb_s2 <= pick;
		end
	end

	assign out_valid = v_s2;
	assign red       = rgb_s2[0];
	assign green     = rgb_s2[1];
	assign blue      = rgb_s2[2];

endmodule

// ===== src/decibel_to_rgb_colormap.sv =====
// ----------------------------------------------------------------------------
// decibel_to_rgb_colormap: spectrogram pixel colormap
// Maps a signed Q8.8 dB level to an rgb color, either on a gray ramp or by
// linear blending of a 19-row color table.
// ----------------------------------------------------------------------------
//
// channel   direction  payload                 handshake
// level_ch  in         level_db (s17, Q8.8)    valid / ready
// rgb_ch    out        red, green, blue (u8)   valid / ready
// cfg       in         cfg_idx, cfg_wdata      cfg_we, no back-pressure
//
// one pixel per cycle sustained while rgb_ch.ready stays high
// the path runs through two front stages (scale, classify), the 13-stage
// divider (one quotient bit per stage) and two blend stages behind
// arst_n clears the stage valid bits and loads the register reset values
// each stage has its own ready, so bubbles close up and a stalled output
// only holds back stages that are full
// ----------------------------------------------------------------------------
module decibel_to_rgb_colormap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dbrgb_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [dbrgb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	dbrgb_level_if.sink                       level_ch,
	dbrgb_rgb_if.source                       rgb_ch
);

	// configuration registers
	logic [dbrgb_pkg::DYN_W-1:0] floor_db_q;
	logic                        gray_mode_q;

	// front end to divider
	logic                 fr_valid;
	logic                 fr_ready;
	dbrgb_pkg::div_item_t fr_item;

	// divider to blend
	logic                 dv_valid;
	logic                 dv_ready;
	dbrgb_pkg::div_item_t dv_item;

	// register writes must happen only while no pixel is in flight (unchecked)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_db_q  <= dbrgb_pkg::FLOOR_DB_RESET;
			gray_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (dbrgb_pkg::cfg_reg_t'(cfg_idx))
				dbrgb_pkg::CFG_FLOOR_DB:  floor_db_q  <= cfg_wdata;
				dbrgb_pkg::CFG_GRAY_MODE: gray_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// scale magnitude and limit, then classify the pixel
	dbrgb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.floor_db  (floor_db_q),
		.gray_mode (gray_mode_q),
		.in_valid  (level_ch.valid),
		.in_ready  (level_ch.ready),
		.level_db  (level_ch.level_db),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_item  (fr_item)
	);

	// scaled magnitude over dynamic range: gray level or table position
	dbrgb_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.floor_db  (floor_db_q),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_item   (fr_item),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_item  (dv_item)
	);

	// blend neighboring rows, round half up, output register
	dbrgb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid),
		.in_ready  (dv_ready),
		.in_item   (dv_item),
		.out_valid (rgb_ch.valid),
		.out_ready (rgb_ch.ready),
		.red       (rgb_ch.red),
		.green     (rgb_ch.green),
		.blue      (rgb_ch.blue)
	);

endmodule
